FILE: hw/rtl/lut1d_interp_extrap_top_defines.svh
// Assertion macros used by the checker file.
`ifndef LUT1D_INTERP_EXTRAP_TOP_DEFINES_SVH
`define LUT1D_INTERP_EXTRAP_TOP_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define LUT1D_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lut1d assertion failed");

// A stalled valid stays up and its payload holds.
`define LUT1D_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) \
    (vld && !rdy) |=> (vld && $stable(sig))) \
    else $error("lut1d handshake hold failed");

`endif

FILE: hw/rtl/lut1d_pkg.sv
package lut1d_pkg;

  localparam int unsigned MAX_POINTS_DEF = 256;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned SIZE_W         = 9;
  localparam int unsigned IDX_W          = 8;
  localparam int unsigned STATUS_W       = 3;
  localparam int unsigned CFG_IDX_W      = 3;
  // quotient bits produced by the divider; larger quotients saturate anyway
  localparam int unsigned DIV_STEPS      = 34;
  localparam int unsigned DIV_CNT_W      = 6;

  typedef enum logic [1:0] {ACT_LOAD, ACT_COMMIT, ACT_LOOKUP, ACT_NOP} action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK, ST_INVALID, ST_EMPTY, ST_SIZE, ST_NOT_RISING
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TABLE_SIZE, REG_SEARCH_MODE, REG_INTERP_MODE, REG_EXTRAP_MODE,
    REG_BELOW_VALUE, REG_ABOVE_VALUE
  } reg_e;

  typedef enum logic [1:0] {SRCH_SEQ, SRCH_BIN, SRCH_NEAR, SRCH_BIN_ALT} search_e;
  typedef enum logic [1:0] {INT_LINEAR, INT_NEAREST, INT_NEXT, INT_PREV} interp_e;
  typedef enum logic [1:0] {EXT_CLIP, EXT_LINEAR, EXT_SPEC, EXT_HOLD} extrap_e;

  // how the result value is formed from the two fetched points
  typedef enum logic [2:0] {
    VK_YA, VK_YB, VK_NEAR, VK_LIN, VK_BELOW, VK_ABOVE, VK_HOLD
  } kind_e;

  typedef enum logic [1:0] {VOP_KEEP, VOP_SET, VOP_CLEAR} vop_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_CK0, S_CK, S_SQ, S_B0, S_B1, S_BS_ISS, S_BS_CMP,
    S_NR_A, S_UP, S_DN, S_VAL, S_RB, S_RC, S_PREP, S_MUL, S_DINIT, S_DIV,
    S_EVAL, S_FIN
  } state_e;

  typedef struct packed {
    logic              capture;
    logic              mem_we;
    logic [SIZE_W-1:0] rd_idx;
    logic              save_prev;
    logic              cap_a;
    logic              cap_b;
    logic              prep;
    logic              mul;
    logic              div_init;
    logic              div_step;
    logic              eval;
    kind_e             kind;
    logic              finish;
    status_e           status;
    vop_e              vop;
    logic              upd_hist;
    logic [SIZE_W-1:0] seg;
  } cmd_t;

  typedef struct packed {
    action_e           action;
    logic              q_lt;
    logic              q_eq;
    logic              prev_ge;
    logic              table_valid;
    logic [SIZE_W-1:0] last_seg;
    logic              out_free;
    logic [SIZE_W-1:0] table_size;
    search_e           search_mode;
    interp_e           interp_mode;
    extrap_e           extrap_mode;
  } stat_t;

endpackage

FILE: hw/rtl/lut1d_if.sv
// Item channel into the block.
interface lut1d_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [1:0]                               action;
  logic [lut1d_pkg::IDX_W-1:0]              entry_index;
  logic signed [lut1d_pkg::DATA_W-1:0]      x_value;
  logic signed [lut1d_pkg::DATA_W-1:0]      y_value;
  modport source (output valid, action, entry_index, x_value, y_value, input ready);
  modport sink   (input valid, action, entry_index, x_value, y_value, output ready);
endinterface

// Result channel out of the block.
interface lut1d_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [lut1d_pkg::DATA_W-1:0]      result;
  logic [lut1d_pkg::STATUS_W-1:0]           status;
  logic [lut1d_pkg::SIZE_W-1:0]             segment;
  logic                                     table_ok;
  modport source (output valid, result, status, segment, table_ok, input ready);
  modport sink   (input valid, result, status, segment, table_ok, output ready);
endinterface

// Register write channel.
interface lut1d_cfg_if;
  logic                                     valid;
  logic                                     ready;
  logic [lut1d_pkg::CFG_IDX_W-1:0]          index;
  logic [lut1d_pkg::DATA_W-1:0]             data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/lut1d_dp.sv
module lut1d_dp #(
  parameter int unsigned MAX_POINTS = lut1d_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lut1d_pkg::cmd_t                     cmd_i,
  output lut1d_pkg::stat_t                    stat_o,
  input  logic [1:0]                          action_i,
  input  logic [lut1d_pkg::IDX_W-1:0]         entry_index_i,
  input  logic signed [lut1d_pkg::DATA_W-1:0] x_value_i,
  input  logic signed [lut1d_pkg::DATA_W-1:0] y_value_i,
  input  logic                                cfg_valid_i,
  input  logic [lut1d_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lut1d_pkg::DATA_W-1:0]        cfg_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [lut1d_pkg::DATA_W-1:0] out_result_o,
  output logic [lut1d_pkg::STATUS_W-1:0]      out_status_o,
  output logic [lut1d_pkg::SIZE_W-1:0]        out_segment_o,
  output logic                                out_table_ok_o
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned DW = lut1d_pkg::DATA_W;
  localparam int unsigned SW = lut1d_pkg::SIZE_W;
  localparam int unsigned QW = lut1d_pkg::DIV_STEPS;
  localparam int unsigned LW = QW + 3;

  // configuration registers
  logic [SW-1:0]               table_size_q;
  lut1d_pkg::search_e          search_mode_q;
  lut1d_pkg::interp_e          interp_mode_q;
  lut1d_pkg::extrap_e          extrap_mode_q;
  logic signed [DW-1:0]        below_q, above_q;
  logic                        table_valid_q;
  logic signed [DW-1:0]        last_result_q;
  logic [SW-1:0]               last_seg_q;

  // item and working registers
  lut1d_pkg::action_e          action_q;
  logic [lut1d_pkg::IDX_W-1:0] idx_q;
  logic signed [DW-1:0]        x_q, y_q;
  logic [2*DW-1:0]             mem [MAX_POINTS];
  logic [2*DW-1:0]             rd_q;
  logic signed [DW-1:0]        rd_x;
  logic signed [DW-1:0]        prev_q, xa_q, ya_q, xb_q, yb_q;
  logic [DW-1:0]               ma_q, mb_q, d_q;
  logic                        neg_q, sat_q;
  logic [2*DW-1:0]             p_q;
  logic [DW-1:0]               rem_q;
  logic [QW-1:0]               qs_q;
  logic signed [DW-1:0]        v_q;

  logic                        out_valid_q;
  logic signed [DW-1:0]        out_result_q;
  lut1d_pkg::status_e          out_status_q;
  logic [SW-1:0]               out_seg_q;
  logic                        out_ok_q;

  logic                        wr_ok, valid_next;
  logic signed [DW:0]          num, dy, dl, dr;
  logic [DW:0]                 rem2, d_ext;
  logic                        div_ge;
  logic [QW:0]                 qadj;
  logic signed [LW-1:0]        ya_ext, q_ext, lin_sum;
  logic signed [DW-1:0]        lin_v, v_d;

  // register writes; a new table size drops the committed table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q  <= '0;
      search_mode_q <= lut1d_pkg::SRCH_BIN;
      interp_mode_q <= lut1d_pkg::INT_LINEAR;
      extrap_mode_q <= lut1d_pkg::EXT_CLIP;
      below_q       <= '0;
      above_q       <= '0;
    end else if (cfg_valid_i) begin
      case (lut1d_pkg::reg_e'(cfg_index_i))
        lut1d_pkg::REG_TABLE_SIZE:  table_size_q  <= cfg_data_i[SW-1:0];
        lut1d_pkg::REG_SEARCH_MODE: search_mode_q <= lut1d_pkg::search_e'(cfg_data_i[1:0]);
        lut1d_pkg::REG_INTERP_MODE: interp_mode_q <= lut1d_pkg::interp_e'(cfg_data_i[1:0]);
        lut1d_pkg::REG_EXTRAP_MODE: extrap_mode_q <= lut1d_pkg::extrap_e'(cfg_data_i[1:0]);
        lut1d_pkg::REG_BELOW_VALUE: below_q       <= $signed(cfg_data_i);
        lut1d_pkg::REG_ABOVE_VALUE: above_q       <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // valid flag after the finishing item
  always_comb begin
    case (cmd_i.vop)
      lut1d_pkg::VOP_SET:   valid_next = 1'b1;
      lut1d_pkg::VOP_CLEAR: valid_next = 1'b0;
      default:              valid_next = table_valid_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_valid_q <= 1'b0;
      last_result_q <= '0;
      last_seg_q    <= '0;
    end else begin
      if (cfg_valid_i && (cfg_index_i == lut1d_pkg::REG_TABLE_SIZE)) begin
        table_valid_q <= 1'b0;
      end else if (cmd_i.finish) begin
        table_valid_q <= valid_next;
      end
      if (cmd_i.finish && cmd_i.upd_hist) begin
        last_result_q <= v_q;
        last_seg_q    <= cmd_i.seg;
      end
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= lut1d_pkg::action_e'(action_i);
      idx_q    <= entry_index_i;
      x_q      <= x_value_i;
      y_q      <= y_value_i;
    end
  end

  // breakpoint memory, x in the upper half of a word
  assign wr_ok = (32'(idx_q) < MAX_POINTS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we && wr_ok) begin
      mem[AW'(idx_q)] <= {x_q, y_q};
    end
    rd_q <= mem[AW'(cmd_i.rd_idx)];
  end

  assign rd_x = $signed(rd_q[2*DW-1:DW]);

  // point and comparison registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.save_prev) prev_q <= rd_x;
    if (cmd_i.cap_a) begin
      xa_q <= rd_x;
      ya_q <= $signed(rd_q[DW-1:0]);
    end
    if (cmd_i.cap_b) begin
      xb_q <= rd_x;
      yb_q <= $signed(rd_q[DW-1:0]);
    end
  end

  // operand magnitudes for the slope term
  assign num = {x_q[DW-1], x_q} - {xa_q[DW-1], xa_q};
  assign dy  = {yb_q[DW-1], yb_q} - {ya_q[DW-1], ya_q};

  // restoring divider step
  assign d_ext  = {1'b0, d_q};
  assign rem2   = {rem_q, qs_q[QW-1]};
  assign div_ge = (rem2 >= d_ext);

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      ma_q  <= num[DW] ? DW'(-num) : num[DW-1:0];
      mb_q  <= dy[DW] ? DW'(-dy) : dy[DW-1:0];
      d_q   <= DW'(xb_q - xa_q);
      neg_q <= num[DW] ^ dy[DW];
    end
    if (cmd_i.mul) begin
      p_q <= (2*DW)'(ma_q) * (2*DW)'(mb_q);
    end
    if (cmd_i.div_init) begin
      sat_q <= (DW'(p_q[2*DW-1:QW]) >= d_q);
      rem_q <= DW'(p_q[2*DW-1:QW]);
      qs_q  <= p_q[QW-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? DW'(rem2 - d_ext) : DW'(rem2);
      qs_q  <= {qs_q[QW-2:0], div_ge};
    end
  end

  // rounding toward minus infinity, then saturation
  assign qadj    = {1'b0, qs_q} + (QW+1)'(neg_q && (rem_q != '0));
  assign ya_ext  = LW'(ya_q);
  assign q_ext   = LW'(qadj);
  assign lin_sum = neg_q ? (ya_ext - q_ext) : (ya_ext + q_ext);

  always_comb begin
    if (sat_q) begin
      lin_v = neg_q ? $signed({1'b1, {(DW-1){1'b0}}}) : $signed({1'b0, {(DW-1){1'b1}}});
    end else if ((&lin_sum[LW-1:DW-1]) || !(|lin_sum[LW-1:DW-1])) begin
      lin_v = lin_sum[DW-1:0];
    end else begin
      lin_v = lin_sum[LW-1] ? $signed({1'b1, {(DW-1){1'b0}}})
                            : $signed({1'b0, {(DW-1){1'b1}}});
    end
  end

  assign dl = {x_q[DW-1], x_q} - {xa_q[DW-1], xa_q};
  assign dr = {xb_q[DW-1], xb_q} - {x_q[DW-1], x_q};

  // value select
  always_comb begin
    case (cmd_i.kind)
      lut1d_pkg::VK_YA:    v_d = ya_q;
      lut1d_pkg::VK_YB:    v_d = yb_q;
      lut1d_pkg::VK_NEAR:  v_d = (dl <= dr) ? ya_q : yb_q;
      lut1d_pkg::VK_LIN:   v_d = lin_v;
      lut1d_pkg::VK_BELOW: v_d = below_q;
      lut1d_pkg::VK_ABOVE: v_d = above_q;
      default:             v_d = last_result_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) v_q <= v_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_result_q <= cmd_i.upd_hist ? v_q : last_result_q;
      out_seg_q    <= cmd_i.upd_hist ? cmd_i.seg : last_seg_q;
      out_status_q <= cmd_i.status;
      out_ok_q     <= valid_next;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_result_o   = out_result_q;
  assign out_status_o   = out_status_q;
  assign out_segment_o  = out_seg_q;
  assign out_table_ok_o = out_ok_q;

  // status toward the controller
  always_comb begin
    stat_o             = '0;
    stat_o.action      = action_q;
    stat_o.q_lt        = (x_q < rd_x);
    stat_o.q_eq        = (x_q == rd_x);
    stat_o.prev_ge     = (prev_q >= rd_x);
    stat_o.table_valid = table_valid_q;
    stat_o.last_seg    = last_seg_q;
    stat_o.out_free    = !out_valid_q || out_ready_i;
    stat_o.table_size  = table_size_q;
    stat_o.search_mode = search_mode_q;
    stat_o.interp_mode = interp_mode_q;
    stat_o.extrap_mode = extrap_mode_q;
  end

endmodule

FILE: hw/rtl/lut1d_ctrl.sv
module lut1d_ctrl #(
  parameter int unsigned MAX_POINTS = lut1d_pkg::MAX_POINTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lut1d_pkg::stat_t stat_i,
  output lut1d_pkg::cmd_t  cmd_o
);

  localparam int unsigned SW = lut1d_pkg::SIZE_W;
  localparam int unsigned CW = lut1d_pkg::DIV_CNT_W;

  lut1d_pkg::state_e  state_q, state_d;
  logic [SW-1:0]      i_q, i_d, lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, b_q, b_d;
  lut1d_pkg::kind_e   kind_q, kind_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  lut1d_pkg::status_e status_q, status_d;
  lut1d_pkg::vop_e    vop_q, vop_d;
  logic               hist_q, hist_d;

  logic [SW-1:0]      n, i_inc, i_dec, near0, mid_c;
  logic               edge_lo, edge_hi, x_gt;

  assign n       = stat_i.table_size;
  assign i_inc   = i_q + SW'(1);
  assign i_dec   = i_q - SW'(1);
  assign near0   = (stat_i.last_seg > n) ? n : stat_i.last_seg;
  assign mid_c   = lo_q + ((hi_q - lo_q) >> 1);
  assign edge_lo = (i_q == '0);
  assign edge_hi = (i_q == n);
  assign x_gt    = !stat_i.q_lt && !stat_i.q_eq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lut1d_pkg::S_IDLE;
      i_q      <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      mid_q    <= '0;
      b_q      <= '0;
      kind_q   <= lut1d_pkg::VK_HOLD;
      cnt_q    <= '0;
      status_q <= lut1d_pkg::ST_OK;
      vop_q    <= lut1d_pkg::VOP_KEEP;
      hist_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      mid_q    <= mid_d;
      b_q      <= b_d;
      kind_q   <= kind_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
      vop_q    <= vop_d;
      hist_q   <= hist_d;
    end
  end

  assign in_ready_o = (state_q == lut1d_pkg::S_IDLE);

  // next state and commands
  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    b_d      = b_q;
    kind_d   = kind_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    vop_d    = vop_q;
    hist_d   = hist_q;
    cmd_o    = '0;
    cmd_o.kind   = kind_q;
    cmd_o.status = status_q;
    cmd_o.vop    = vop_q;
    cmd_o.seg    = i_q;

    case (state_q)
      lut1d_pkg::S_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = lut1d_pkg::S_DISP;
      end

      lut1d_pkg::S_DISP: begin
        status_d = lut1d_pkg::ST_OK;
        vop_d    = lut1d_pkg::VOP_KEEP;
        hist_d   = 1'b0;
        state_d  = lut1d_pkg::S_FIN;
        case (stat_i.action)
          lut1d_pkg::ACT_LOAD: begin
            cmd_o.mem_we = 1'b1;
            vop_d        = lut1d_pkg::VOP_CLEAR;
          end
          lut1d_pkg::ACT_COMMIT: begin
            if (n == '0) begin
              status_d = lut1d_pkg::ST_EMPTY;
              vop_d    = lut1d_pkg::VOP_CLEAR;
            end else if ((n < SW'(2)) || (32'(n) > MAX_POINTS)) begin
              status_d = lut1d_pkg::ST_SIZE;
              vop_d    = lut1d_pkg::VOP_CLEAR;
            end else begin
              cmd_o.rd_idx = '0;
              state_d      = lut1d_pkg::S_CK0;
            end
          end
          lut1d_pkg::ACT_LOOKUP: begin
            if (!stat_i.table_valid) begin
              status_d = lut1d_pkg::ST_INVALID;
              vop_d    = lut1d_pkg::VOP_CLEAR;
            end else begin
              i_d          = '0;
              cmd_o.rd_idx = '0;
              state_d      = (stat_i.search_mode == lut1d_pkg::SRCH_SEQ) ?
                             lut1d_pkg::S_SQ : lut1d_pkg::S_B0;
            end
          end
          default: ;
        endcase
      end

      // strictly rising check, one breakpoint per cycle
      lut1d_pkg::S_CK0: begin
        cmd_o.save_prev = 1'b1;
        i_d             = SW'(1);
        cmd_o.rd_idx    = SW'(1);
        state_d         = lut1d_pkg::S_CK;
      end

      lut1d_pkg::S_CK: begin
        if (stat_i.prev_ge) begin
          status_d = lut1d_pkg::ST_NOT_RISING;
          vop_d    = lut1d_pkg::VOP_CLEAR;
          state_d  = lut1d_pkg::S_FIN;
        end else if (i_inc == n) begin
          vop_d   = lut1d_pkg::VOP_SET;
          state_d = lut1d_pkg::S_FIN;
        end else begin
          cmd_o.save_prev = 1'b1;
          i_d             = i_inc;
          cmd_o.rd_idx    = i_inc;
        end
      end

      // sequential search
      lut1d_pkg::S_SQ: begin
        if (stat_i.q_lt || stat_i.q_eq) begin
          state_d = lut1d_pkg::S_VAL;
        end else begin
          i_d = i_inc;
          if (i_inc == n) begin
            state_d = lut1d_pkg::S_VAL;
          end else begin
            cmd_o.rd_idx = i_inc;
          end
        end
      end

      // end checks ahead of binary and near search
      lut1d_pkg::S_B0: begin
        if (stat_i.q_lt || stat_i.q_eq) begin
          i_d     = '0;
          state_d = lut1d_pkg::S_VAL;
        end else begin
          cmd_o.rd_idx = n - SW'(1);
          state_d      = lut1d_pkg::S_B1;
        end
      end

      lut1d_pkg::S_B1: begin
        if (!stat_i.q_lt) begin
          i_d     = n;
          state_d = lut1d_pkg::S_VAL;
        end else if (stat_i.search_mode == lut1d_pkg::SRCH_NEAR) begin
          i_d = near0;
          if (near0 == n) begin
            cmd_o.rd_idx = near0 - SW'(1);
            state_d      = lut1d_pkg::S_DN;
          end else begin
            cmd_o.rd_idx = near0;
            state_d      = lut1d_pkg::S_NR_A;
          end
        end else begin
          lo_d    = '0;
          hi_d    = n - SW'(1);
          state_d = lut1d_pkg::S_BS_ISS;
        end
      end

      lut1d_pkg::S_BS_ISS: begin
        if (lo_q < hi_q) begin
          mid_d        = mid_c;
          cmd_o.rd_idx = mid_c;
          state_d      = lut1d_pkg::S_BS_CMP;
        end else begin
          i_d     = lo_q;
          state_d = lut1d_pkg::S_VAL;
        end
      end

      lut1d_pkg::S_BS_CMP: begin
        if (stat_i.q_eq) begin
          i_d     = mid_q;
          state_d = lut1d_pkg::S_VAL;
        end else begin
          if (stat_i.q_lt) hi_d = mid_q;
          else             lo_d = mid_q + SW'(1);
          state_d = lut1d_pkg::S_BS_ISS;
        end
      end

      // near search: x[i] in hand, pick a direction
      lut1d_pkg::S_NR_A, lut1d_pkg::S_UP: begin
        if (stat_i.q_lt && (state_q == lut1d_pkg::S_NR_A)) begin
          if (i_q != '0) begin
            cmd_o.rd_idx = i_dec;
            state_d      = lut1d_pkg::S_DN;
          end else begin
            state_d = lut1d_pkg::S_VAL;
          end
        end else if (x_gt) begin
          i_d = i_inc;
          if (i_inc == n) begin
            state_d = lut1d_pkg::S_VAL;
          end else begin
            cmd_o.rd_idx = i_inc;
            state_d      = lut1d_pkg::S_UP;
          end
        end else begin
          state_d = lut1d_pkg::S_VAL;
        end
      end

      // walk down while x is below x[i-1]
      lut1d_pkg::S_DN: begin
        if (stat_i.q_lt) begin
          i_d = i_dec;
          if (i_dec == '0) begin
            state_d = lut1d_pkg::S_VAL;
          end else begin
            cmd_o.rd_idx = i_dec - SW'(1);
          end
        end else begin
          state_d = lut1d_pkg::S_VAL;
        end
      end

      // choose the two points and the value form
      lut1d_pkg::S_VAL: begin
        status_d = lut1d_pkg::ST_OK;
        hist_d   = 1'b1;
        state_d  = lut1d_pkg::S_RB;
        if (edge_lo || edge_hi) begin
          case (stat_i.extrap_mode)
            lut1d_pkg::EXT_CLIP: begin
              cmd_o.rd_idx = edge_lo ? '0 : n - SW'(1);
              b_d          = cmd_o.rd_idx;
              kind_d       = lut1d_pkg::VK_YA;
            end
            lut1d_pkg::EXT_LINEAR: begin
              cmd_o.rd_idx = edge_lo ? '0 : n - SW'(2);
              b_d          = edge_lo ? SW'(1) : n - SW'(1);
              kind_d       = lut1d_pkg::VK_LIN;
            end
            lut1d_pkg::EXT_SPEC: begin
              kind_d = edge_lo ? lut1d_pkg::VK_BELOW : lut1d_pkg::VK_ABOVE;
            end
            default: kind_d = lut1d_pkg::VK_HOLD;
          endcase
        end else begin
          cmd_o.rd_idx = i_dec;
          b_d          = i_q;
          case (stat_i.interp_mode)
            lut1d_pkg::INT_LINEAR:  kind_d = lut1d_pkg::VK_LIN;
            lut1d_pkg::INT_NEAREST: kind_d = lut1d_pkg::VK_NEAR;
            lut1d_pkg::INT_NEXT:    kind_d = lut1d_pkg::VK_YB;
            default:                kind_d = lut1d_pkg::VK_YA;
          endcase
        end
      end

      lut1d_pkg::S_RB: begin
        cmd_o.cap_a  = 1'b1;
        cmd_o.rd_idx = b_q;
        state_d      = lut1d_pkg::S_RC;
      end

      lut1d_pkg::S_RC: begin
        cmd_o.cap_b = 1'b1;
        state_d     = (kind_q == lut1d_pkg::VK_LIN) ? lut1d_pkg::S_PREP : lut1d_pkg::S_EVAL;
      end

      lut1d_pkg::S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = lut1d_pkg::S_MUL;
      end

      lut1d_pkg::S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = lut1d_pkg::S_DINIT;
      end

      lut1d_pkg::S_DINIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = lut1d_pkg::S_DIV;
      end

      lut1d_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CW'(1);
        if (cnt_q == CW'(lut1d_pkg::DIV_STEPS - 1)) state_d = lut1d_pkg::S_EVAL;
      end

      lut1d_pkg::S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = lut1d_pkg::S_FIN;
      end

      lut1d_pkg::S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.finish   = 1'b1;
          cmd_o.upd_hist = hist_q;
          state_d        = lut1d_pkg::S_IDLE;
        end
      end

      default: state_d = lut1d_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/lut1d_interp_extrap_top.sv
// One-dimensional Q16.16 breakpoint table with interpolation and extrapolation.
// Items are handled one at a time; a new item is taken while the previous
// result still sits in the output register. The breakpoint memory has one
// read port, which sets the pace: a commit compares one breakpoint per cycle,
// and a lookup searches sequentially, by binary search or by walking from the
// last segment (near). Linear interpolation and linear extrapolation add one
// multiply and a 34-step restoring divider.
module lut1d_interp_extrap_top #(
  parameter int unsigned MAX_POINTS = lut1d_pkg::MAX_POINTS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lut1d_in_if.sink     in_i,
  lut1d_out_if.source  out_o,
  lut1d_cfg_if.sink    cfg_i
);

  lut1d_pkg::cmd_t  cmd;
  lut1d_pkg::stat_t stat;
  logic             in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  // sequencer
  lut1d_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // storage and arithmetic
  lut1d_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .action_i       (in_i.action),
    .entry_index_i  (in_i.entry_index),
    .x_value_i      (in_i.x_value),
    .y_value_i      (in_i.y_value),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .out_result_o   (out_o.result),
    .out_status_o   (out_o.status),
    .out_segment_o  (out_o.segment),
    .out_table_ok_o (out_o.table_ok)
  );

endmodule

FILE: hw/rtl/lut1d_checker.sv
`include "lut1d_interp_extrap_top_defines.svh"

module lut1d_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic signed [lut1d_pkg::DATA_W-1:0] out_result_i,
  input logic [lut1d_pkg::STATUS_W-1:0]      out_status_i,
  input logic                                out_table_ok_i
);

  // a waiting result holds its value
  `LUT1D_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_i, out_ready_i, out_result_i)

  // status codes stay within the defined set
  `LUT1D_ASSERT_IMPL(a_status_range, clk_i, rst_ni, out_valid_i, out_status_i <= lut1d_pkg::ST_NOT_RISING)

  // any failure leaves the table invalid
  `LUT1D_ASSERT_IMPL(a_err_invalid, clk_i, rst_ni, out_valid_i && (out_status_i != lut1d_pkg::ST_OK), !out_table_ok_i)

endmodule

bind lut1d_interp_extrap_top lut1d_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_result_i   (out_o.result),
  .out_status_i   (out_o.status),
  .out_table_ok_i (out_o.table_ok)
);
